// ===== src/hpq_pkg.sv =====
// shared types and codes for the binary heap priority queue
package hpq_pkg;

    localparam int OCC_W    = 4;
    localparam int STATUS_W = 2;

    localparam logic MODE_INSERT  = 1'b0;
    localparam logic MODE_EXTRACT = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [21:0] owner_pid;
        logic [7:0]  producer;
        logic [7:0]  priority_lvl;
        logic [7:0]  duration;
        logic [16:0] ident;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EX_LOAD,
        S_SIFT_UP,
        S_SIFT_DOWN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic start;
        logic ex_load;
        logic up_step;
        logic dn_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic up_stop;
        logic dn_stop;
    } t_dp_sts;

endpackage

// ===== src/hpq_ram.sv =====
// generic single write, dual read ram with registered read data
module hpq_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    output logic [WIDTH-1:0]         o_rdata0,
    input  logic                     i_re1,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re0) begin
            r_rdata0 <= r_mem[i_raddr0];
        end
        if (i_re1) begin
            r_rdata1 <= r_mem[i_raddr1];
        end
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// ===== src/hpq_ctrl.sv =====
// sequencing state machine and result valid flag of the heap queue
module hpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_mode,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  hpq_pkg::t_dp_sts i_sts,
    output hpq_pkg::t_dp_cmd o_cmd
);

    hpq_pkg::t_state r_state;
    hpq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            hpq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == hpq_pkg::MODE_INSERT) begin
                        n_state = i_sts.full ? hpq_pkg::S_FINISH : hpq_pkg::S_SIFT_UP;
                    end else begin
                        n_state = i_sts.empty ? hpq_pkg::S_FINISH : hpq_pkg::S_EX_LOAD;
                    end
                end
            end
            hpq_pkg::S_EX_LOAD: begin
                n_state = i_sts.last_one ? hpq_pkg::S_FINISH : hpq_pkg::S_SIFT_DOWN;
            end
            hpq_pkg::S_SIFT_UP: begin
                if (i_sts.up_stop) begin
                    n_state = hpq_pkg::S_FINISH;
                end
            end
            hpq_pkg::S_SIFT_DOWN: begin
                if (i_sts.dn_stop) begin
                    n_state = hpq_pkg::S_FINISH;
                end
            end
            hpq_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = hpq_pkg::S_IDLE;
                end
            end
            default: n_state = hpq_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            hpq_pkg::S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            hpq_pkg::S_EX_LOAD:   o_cmd.ex_load = 1'b1;
            hpq_pkg::S_SIFT_UP:   o_cmd.up_step = 1'b1;
            hpq_pkg::S_SIFT_DOWN: o_cmd.dn_step = 1'b1;
            hpq_pkg::S_FINISH:    o_cmd.out_load = w_out_free;
            default: o_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hpq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/hpq_datapath.sv =====
// heap storage, sift compare logic and result register of the heap queue
module hpq_datapath #(
    parameter int CAPACITY = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  hpq_pkg::t_dp_cmd               i_cmd,
    output hpq_pkg::t_dp_sts               o_sts,
    input  logic                           i_mode,
    input  hpq_pkg::t_job                  i_job,
    output logic [hpq_pkg::STATUS_W-1:0]   o_status,
    output hpq_pkg::t_job                  o_job,
    output logic [hpq_pkg::OCC_W-1:0]      o_occupancy
);

    // positions are 1-based heap slots, slot p lives at ram address p-1
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    function automatic logic [AW-1:0] f_addr(input logic [PW:0] pos);
        logic [PW:0] d;
        d = pos - (PW+1)'(1);
        return d[AW-1:0];
    endfunction

    logic [PW-1:0]                  r_count;
    logic [PW-1:0]                  r_pos;
    hpq_pkg::t_job                  r_x;
    hpq_pkg::t_job                  r_got;
    logic [hpq_pkg::STATUS_W-1:0]   r_status;
    logic [hpq_pkg::STATUS_W-1:0]   r_o_status;
    hpq_pkg::t_job                  r_o_job;
    logic [hpq_pkg::OCC_W-1:0]      r_o_occ;

    logic                           w_we;
    logic [AW-1:0]                  w_waddr;
    hpq_pkg::t_job                  w_wdata;
    logic                           w_re0;
    logic                           w_re1;
    logic [AW-1:0]                  w_raddr0;
    logic [AW-1:0]                  w_raddr1;
    hpq_pkg::t_job                  w_rd0;
    hpq_pkg::t_job                  w_rd1;

    logic [PW-1:0]                  w_cnt_inc;
    logic [PW-1:0]                  w_cnt_dec;
    logic [PW-1:0]                  w_parent;
    logic                           w_full;
    logic                           w_empty;
    logic                           w_up_stop;
    logic [PW:0]                    w_left;
    logic [PW:0]                    w_right;
    logic                           w_take_left;
    logic                           w_take_right;
    logic [7:0]                     w_best_pri;
    logic                           w_dn_stop;
    logic [PW-1:0]                  w_child;
    logic [PW-1:0]                  w_cp;
    logic [PW-1:0]                  w_cc;
    logic [PW:0]                    w_cl;
    logic [PW:0]                    w_cr;

    assign w_cnt_inc = r_count + PW'(1);
    assign w_cnt_dec = r_count - PW'(1);
    assign w_parent  = r_pos >> 1;
    assign w_full    = (r_count == PW'(CAPACITY));
    assign w_empty   = (r_count == '0);

    // parent wins only with strictly greater priority
    assign w_up_stop = (r_pos == PW'(1)) || (w_rd0.priority_lvl > r_x.priority_lvl);

    // left child tried first, right must beat the current best
    assign w_left       = {r_pos, 1'b0};
    assign w_right      = w_left + (PW+1)'(1);
    assign w_take_left  = (w_left <= {1'b0, r_count})
                          && (w_rd0.priority_lvl > r_x.priority_lvl);
    assign w_best_pri   = w_take_left ? w_rd0.priority_lvl : r_x.priority_lvl;
    assign w_take_right = (w_right <= {1'b0, r_count}) && (w_rd1.priority_lvl > w_best_pri);
    assign w_dn_stop    = !w_take_left && !w_take_right;
    assign w_child      = w_take_right ? w_right[PW-1:0] : w_left[PW-1:0];

    // children of the slot the sift down moves to next
    assign w_cp = i_cmd.dn_step ? w_child : PW'(1);
    assign w_cc = i_cmd.dn_step ? r_count : w_cnt_dec;
    assign w_cl = {w_cp, 1'b0};
    assign w_cr = w_cl + (PW+1)'(1);

    always_comb begin
        w_we     = 1'b0;
        w_waddr  = f_addr({1'b0, r_pos});
        w_wdata  = r_x;
        w_re0    = 1'b0;
        w_re1    = 1'b0;
        w_raddr0 = '0;
        w_raddr1 = '0;
        if (i_cmd.start) begin
            if (i_mode == hpq_pkg::MODE_INSERT) begin
                w_re0    = !w_full && !w_empty;
                w_raddr0 = f_addr({1'b0, w_cnt_inc >> 1});
            end else begin
                w_re0    = !w_empty;
                w_raddr0 = '0;
                w_re1    = !w_empty;
                w_raddr1 = f_addr({1'b0, r_count});
            end
        end
        if (i_cmd.up_step) begin
            w_we = 1'b1;
            if (!w_up_stop) begin
                w_wdata  = w_rd0;
                w_re0    = (w_parent > PW'(1));
                w_raddr0 = f_addr({1'b0, w_parent >> 1});
            end
        end
        if (i_cmd.dn_step) begin
            w_we = 1'b1;
            if (!w_dn_stop) begin
                w_wdata = w_take_right ? w_rd1 : w_rd0;
            end
        end
        if (i_cmd.ex_load || (i_cmd.dn_step && !w_dn_stop)) begin
            w_re0    = (w_cl <= {1'b0, w_cc});
            w_raddr0 = f_addr(w_cl);
            w_re1    = (w_cr <= {1'b0, w_cc});
            w_raddr1 = f_addr(w_cr);
        end
    end

    hpq_ram #(
        .WIDTH(hpq_pkg::JOB_W),
        .DEPTH(CAPACITY)
    ) u_heap_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re0   (w_re0),
        .i_raddr0(w_raddr0),
        .o_rdata0(w_rd0),
        .i_re1   (w_re1),
        .i_raddr1(w_raddr1),
        .o_rdata1(w_rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.start && i_mode == hpq_pkg::MODE_INSERT && !w_full) begin
            r_count <= w_cnt_inc;
        end else if (i_cmd.ex_load) begin
            r_count <= w_cnt_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_got <= '0;
            if (i_mode == hpq_pkg::MODE_INSERT) begin
                r_status <= w_full ? hpq_pkg::STATUS_FULL : hpq_pkg::STATUS_DONE;
                r_x      <= i_job;
                r_pos    <= w_cnt_inc;
            end else begin
                r_status <= w_empty ? hpq_pkg::STATUS_EMPTY : hpq_pkg::STATUS_DONE;
            end
        end
        if (i_cmd.ex_load) begin
            r_got <= w_rd0;
            r_x   <= w_rd1;
            r_pos <= PW'(1);
        end
        if (i_cmd.up_step && !w_up_stop) begin
            r_pos <= w_parent;
        end
        if (i_cmd.dn_step && !w_dn_stop) begin
            r_pos <= w_child;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_job    <= r_got;
            r_o_occ    <= hpq_pkg::OCC_W'(r_count);
        end
    end

    assign o_sts.full     = w_full;
    assign o_sts.empty    = w_empty;
    assign o_sts.last_one = (r_count == PW'(1));
    assign o_sts.up_stop  = w_up_stop;
    assign o_sts.dn_stop  = w_dn_stop;

    assign o_status    = r_o_status;
    assign o_job       = r_o_job;
    assign o_occupancy = r_o_occ;

endmodule

// ===== src/binary_heap_priority_queue.sv =====
// top level of the bounded max-priority job queue kept as a binary heap
//
//  channel | handshake                 | payload
//  --------+---------------------------+--------------------------------------------
//  input   | i_in_valid / o_in_ready   | i_mode, i_job_owner_pid .. i_job_ident
//  output  | o_out_valid / i_out_ready | o_status, o_out_owner_pid .. o_occupancy
//
// one item at a time; an insert sifts its job up, an extract loads the root and the last slot
// and sifts down, moving at most log2(CAPACITY) levels with one ram read and compare per heap level
// a full insert or empty extract goes straight to the final step
// synchronous active-low reset empties the queue; heap ram contents are not cleared
// a held result stalls only the final step; a new transfer is taken while it waits
module binary_heap_priority_queue #(
    parameter int CAPACITY = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_mode,
    input  logic [21:0] i_job_owner_pid,
    input  logic [7:0]  i_job_producer,
    input  logic [7:0]  i_job_priority,
    input  logic [7:0]  i_job_duration,
    input  logic [16:0] i_job_ident,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [21:0] o_out_owner_pid,
    output logic [7:0]  o_out_producer,
    output logic [7:0]  o_out_priority,
    output logic [7:0]  o_out_duration,
    output logic [16:0] o_out_ident,
    output logic [3:0]  o_occupancy
);

    hpq_pkg::t_dp_cmd w_cmd;
    hpq_pkg::t_dp_sts w_sts;
    hpq_pkg::t_job    w_in_job;
    hpq_pkg::t_job    w_out_job;

    assign w_in_job.owner_pid    = i_job_owner_pid;
    assign w_in_job.producer     = i_job_producer;
    assign w_in_job.priority_lvl = i_job_priority;
    assign w_in_job.duration     = i_job_duration;
    assign w_in_job.ident        = i_job_ident;

    hpq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_mode     (i_mode),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    hpq_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_mode     (i_mode),
        .i_job      (w_in_job),
        .o_status   (o_status),
        .o_job      (w_out_job),
        .o_occupancy(o_occupancy)
    );

    assign o_out_owner_pid = w_out_job.owner_pid;
    assign o_out_producer  = w_out_job.producer;
    assign o_out_priority  = w_out_job.priority_lvl;
    assign o_out_duration  = w_out_job.duration;
    assign o_out_ident     = w_out_job.ident;

endmodule

// ===== src/hpq_checker.sv =====
// port level checks of the heap queue, bound to the top level
module hpq_checker #(
    parameter int CAPACITY = 8
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_status,
    input logic [21:0] o_out_owner_pid,
    input logic [7:0]  o_out_producer,
    input logic [7:0]  o_out_priority,
    input logic [7:0]  o_out_duration,
    input logic [16:0] o_out_ident,
    input logic [3:0]  o_occupancy
);

    localparam logic [3:0] CAP_OCC = 4'(CAPACITY);

    // a transfer starts work, so the input side is not ready in the cycle after it
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // an empty report leaves an empty queue and no job
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hpq_pkg::STATUS_EMPTY)
        |-> (o_occupancy == '0 && o_out_priority == '0 && o_out_ident == '0))
        else $error("empty status with data or occupancy");

    // a full report shows the queue at capacity
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == hpq_pkg::STATUS_FULL) |-> (o_occupancy == CAP_OCC))
        else $error("full status below capacity");

    // a result only follows a taken item, never one in the cycle after reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_out_owner_pid) && $stable(o_out_producer)
            && $stable(o_out_priority) && $stable(o_out_duration)
            && $stable(o_out_ident) && $stable(o_occupancy)))
        else $error("stalled result changed");

endmodule

bind binary_heap_priority_queue hpq_checker #(.CAPACITY(CAPACITY)) u_hpq_checker (.*);

// ===== sim/tb.sv =====
// testbench for the binary heap priority queue: heap predictor, stimulus phases and result checks
`timescale 1ns / 100ps

module tb;

    localparam int HEAP_DEPTH   = 8;
    localparam int SETTLE_CYCLES = 16;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [hpq_pkg::STATUS_W-1:0] status;
        hpq_pkg::t_job                job;
        logic [hpq_pkg::OCC_W-1:0]    occupancy;
    } t_queue_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_mode = hpq_pkg::MODE_INSERT;
    logic [21:0] i_job_owner_pid = '0;
    logic [7:0]  i_job_producer = '0;
    logic [7:0]  i_job_priority = '0;
    logic [7:0]  i_job_duration = '0;
    logic [16:0] i_job_ident = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [21:0] o_out_owner_pid;
    logic [7:0]  o_out_producer;
    logic [7:0]  o_out_priority;
    logic [7:0]  o_out_duration;
    logic [16:0] o_out_ident;
    logic [3:0]  o_occupancy;

    // predictor state
    hpq_pkg::t_job heap_slots [1:HEAP_DEPTH];
    int            heap_count = 0;
    t_queue_result expected_results [$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_len = 0;
    int rx_hold_token = 0;
    int hold_token_seen = 0;
    int hold_left = 0;

    int mismatch_count = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_empty = 0;

    binary_heap_priority_queue #(.CAPACITY(HEAP_DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_job_owner_pid (i_job_owner_pid),
        .i_job_producer  (i_job_producer),
        .i_job_priority  (i_job_priority),
        .i_job_duration  (i_job_duration),
        .i_job_ident     (i_job_ident),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_out_owner_pid (o_out_owner_pid),
        .o_out_producer  (o_out_producer),
        .o_out_priority  (o_out_priority),
        .o_out_duration  (o_out_duration),
        .o_out_ident     (o_out_ident),
        .o_occupancy     (o_occupancy)
    );

    always #5 i_clk = ~i_clk;

    task automatic swap_slots(input int a, input int b);
        hpq_pkg::t_job tmp;
        tmp = heap_slots[a];
        heap_slots[a] = heap_slots[b];
        heap_slots[b] = tmp;
    endtask

    task automatic predict_queue_op(input logic mode, input hpq_pkg::t_job job);
        t_queue_result r;
        int pos;
        int up;
        int best;
        int l;
        int rt;
        bit done;
        r = '0;
        r.status = hpq_pkg::STATUS_DONE;
        if (mode == hpq_pkg::MODE_INSERT) begin
            if (heap_count >= HEAP_DEPTH) begin
                r.status = hpq_pkg::STATUS_FULL;
                n_full++;
            end else begin
                heap_count++;
                heap_slots[heap_count] = job;
                pos = heap_count;
                done = 1'b0;
                // equal priority keeps rising
                while (pos > 1 && !done) begin
                    up = pos / 2;
                    if (heap_slots[up].priority_lvl > heap_slots[pos].priority_lvl) begin
                        done = 1'b1;
                    end else begin
                        swap_slots(up, pos);
                        pos = up;
                    end
                end
            end
        end else begin
            if (heap_count == 0) begin
                r.status = hpq_pkg::STATUS_EMPTY;
                n_empty++;
            end else begin
                r.job = heap_slots[1];
                heap_slots[1] = heap_slots[heap_count];
                heap_count--;
                pos = 1;
                done = 1'b0;
                // left child first, strictly greater only
                while (pos <= heap_count && !done) begin
                    l = 2 * pos;
                    rt = 2 * pos + 1;
                    best = pos;
                    if (l <= heap_count) begin
                        if (heap_slots[l].priority_lvl > heap_slots[best].priority_lvl)
                            best = l;
                    end
                    if (rt <= heap_count) begin
                        if (heap_slots[rt].priority_lvl > heap_slots[best].priority_lvl)
                            best = rt;
                    end
                    if (best == pos) begin
                        done = 1'b1;
                    end else begin
                        swap_slots(best, pos);
                        pos = best;
                    end
                end
            end
        end
        r.occupancy = hpq_pkg::OCC_W'(heap_count);
        expected_results.push_back(r);
    endtask

    // predict on every input transfer
    always @(posedge i_clk) begin
        hpq_pkg::t_job j;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            j.owner_pid    = i_job_owner_pid;
            j.producer     = i_job_producer;
            j.priority_lvl = i_job_priority;
            j.duration     = i_job_duration;
            j.ident        = i_job_ident;
            predict_queue_op(i_mode, j);
        end
    end

    // compare every output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_queue_result e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("result with no prediction pending: status %0d", o_status);
                mismatch_count++;
            end else begin
                e = expected_results.pop_front();
                n_checked++;
                if (o_status !== e.status) begin
                    $error("o_status expected %0d got %0d", e.status, o_status);
                    mismatch_count++;
                end
                if (o_out_owner_pid !== e.job.owner_pid) begin
                    $error("o_out_owner_pid expected %0h got %0h",
                           e.job.owner_pid, o_out_owner_pid);
                    mismatch_count++;
                end
                if (o_out_producer !== e.job.producer) begin
                    $error("o_out_producer expected %0h got %0h",
                           e.job.producer, o_out_producer);
                    mismatch_count++;
                end
                if (o_out_priority !== e.job.priority_lvl) begin
                    $error("o_out_priority expected %0d got %0d",
                           e.job.priority_lvl, o_out_priority);
                    mismatch_count++;
                end
                if (o_out_duration !== e.job.duration) begin
                    $error("o_out_duration expected %0h got %0h",
                           e.job.duration, o_out_duration);
                    mismatch_count++;
                end
                if (o_out_ident !== e.job.ident) begin
                    $error("o_out_ident expected %0h got %0h", e.job.ident, o_out_ident);
                    mismatch_count++;
                end
                if (o_occupancy !== e.occupancy) begin
                    $error("o_occupancy expected %0d got %0d", e.occupancy, o_occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (rx_hold_token != hold_token_seen) begin
            hold_token_seen <= rx_hold_token;
            hold_left <= rx_hold_len;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_queue_op(input logic mode, input hpq_pkg::t_job job);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_job_owner_pid <= job.owner_pid;
        i_job_producer  <= job.producer;
        i_job_priority  <= job.priority_lvl;
        i_job_duration  <= job.duration;
        i_job_ident     <= job.ident;
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    function automatic hpq_pkg::t_job make_job(input logic [7:0] prio);
        hpq_pkg::t_job j;
        j.owner_pid    = 22'($urandom);
        j.producer     = 8'($urandom);
        j.priority_lvl = prio;
        j.duration     = 8'($urandom);
        j.ident        = 17'($urandom);
        return j;
    endfunction

    function automatic logic [7:0] random_priority();
        logic [7:0] p;
        case ($urandom_range(3))
            0: p = 8'($urandom_range(3));          // ties
            1: p = $urandom_range(1) ? 8'hff : 8'h00;
            default: p = 8'($urandom_range(255));
        endcase
        return p;
    endfunction

    // bursts biased toward filling, draining or balanced so full and empty recur
    task automatic send_random_ops(input int count);
        int insert_pct;
        logic mode;
        insert_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) begin
                case ($urandom_range(2))
                    0: insert_pct = 80;
                    1: insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            mode = ($urandom_range(99) < insert_pct) ? hpq_pkg::MODE_INSERT
                                                      : hpq_pkg::MODE_EXTRACT;
            send_queue_op(mode, make_job(random_priority()));
        end
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed_edges();
        hpq_pkg::t_job ones;
        logic [7:0] prios [8];
        ones = '1;
        prios = '{8'd5, 8'd5, 8'd255, 8'd0, 8'd5, 8'd7, 8'd7, 8'd1};
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        send_queue_op(hpq_pkg::MODE_EXTRACT, ones);      // empty queue, payload ignored
        send_queue_op(hpq_pkg::MODE_INSERT, ones);
        send_queue_op(hpq_pkg::MODE_INSERT, '0);
        send_queue_op(hpq_pkg::MODE_EXTRACT, '0);
        send_queue_op(hpq_pkg::MODE_EXTRACT, ones);
        for (int k = 0; k < HEAP_DEPTH; k++)
            send_queue_op(hpq_pkg::MODE_INSERT, make_job(prios[k]));
        send_queue_op(hpq_pkg::MODE_INSERT, ones);       // full queue
        for (int k = 0; k <= HEAP_DEPTH; k++)
            send_queue_op(hpq_pkg::MODE_EXTRACT, '0);
        wait_results_drained();
    endtask

    task automatic test_back_to_back();
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        send_random_ops(330);
        wait_results_drained();
    endtask

    task automatic test_sender_gaps();
        tx_idle_pct = 85;
        rx_stall_pct <= 0;
        send_random_ops(330);
        wait_results_drained();
    endtask

    task automatic test_receiver_stalls();
        tx_idle_pct = 0;
        rx_stall_pct <= 85;
        send_random_ops(330);
        wait_results_drained();
    endtask

    task automatic test_both_idle();
        tx_idle_pct = 19;
        rx_stall_pct <= 19;
        send_random_ops(330);
        wait_results_drained();
    endtask

    // output held off while inputs keep coming, so the input side backs up
    task automatic test_output_hold_off();
        tx_idle_pct = 0;
        rx_stall_pct <= 0;
        rx_hold_len <= HOLD_CYCLES;
        rx_hold_token <= rx_hold_token + 1;
        send_random_ops(16);
        wait_results_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_back_to_back();
        test_output_hold_off();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        $display("covered %0d input transfers and %0d checked results over five idle patterns",
                 n_sent, n_checked);
        $display("queue full seen %0d times, queue empty seen %0d times", n_full, n_empty);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sim.f =====
src/hpq_pkg.sv
src/hpq_ram.sv
src/hpq_ctrl.sv
src/hpq_datapath.sv
src/binary_heap_priority_queue.sv
src/hpq_checker.sv
sim/tb.sv
